@@ sv/drd_pkg.sv @@
package drd_pkg;

  typedef enum logic [1:0] {
    OP_VICTIM = 2'd0,
    OP_UPDATE = 2'd1,
    OP_DECAY  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  localparam int unsigned OpBits    = 2;
  localparam int unsigned SetBits   = 11;
  localparam int unsigned WayBits   = 4;
  localparam int unsigned AddrBits  = 64;
  localparam int unsigned SelBits   = 10;
  localparam int unsigned ThrBits   = 3;
  localparam int unsigned NumSets    = 2048;
  localparam int unsigned NumWays    = 16;
  localparam int unsigned LeaderSets = 64;
  localparam logic [15:0] LfsrSeed  = 16'hACE1;
  localparam logic [AddrBits-1:0] StrideOne = 64'd64;
  localparam logic [AddrBits-1:0] StrideTwo = 64'd128;

  typedef struct packed {
    logic [OpBits-1:0]   operation;
    logic [SetBits-1:0]  set_index;
    logic [WayBits-1:0]  way_index;
    logic [AddrBits-1:0] phys_addr;
    logic                was_hit;
  } req_t;

  typedef struct packed {
    logic [WayBits-1:0] victim_way;
    logic               set_streaming;
    logic [SelBits-1:0] duel_counter;
  } rsp_t;

endpackage

@@ sv/dip_rrip_deadblock_stream_replacement.sv @@
// Replacement policy for a last-level cache: 2-bit SRRIP with DIP set dueling,
// per-block dead counters and a per-set stride streaming detector. Each word
// on the request channel gives exactly one word on the response channel, and
// requests are handled one at a time, so no two accesses to a set row overlap.
// An update reads the row of the set memories, writes it back and then
// gives its response. A victim request reads the row and scans it, with one
// aging round of the RRPV row each time no way qualifies (at most three),
// then passes the write state and gives its response. A decay walks every set
// row, one row per cycle, then reads back the addressed set before its
// response. A response word that is not taken holds the next request in its
// response cycle. After reset a clearing pass writes every row of the
// memories before the first request is taken. Writes to the streaming
// threshold take effect at the next edge and belong between requests.
module dip_rrip_deadblock_stream_replacement (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_wdata_i,
  input  logic                 req_valid_i,
  output logic                 req_ready_o,
  input  drd_pkg::req_t        req_i,
  output logic                 rsp_valid_o,
  input  logic                 rsp_ready_i,
  output drd_pkg::rsp_t        rsp_o
);

  localparam int unsigned SIdx = $clog2(drd_pkg::NumSets);
  localparam int unsigned WIdx = $clog2(drd_pkg::NumWays);
  localparam logic [drd_pkg::SelBits-1:0] SelMax = {drd_pkg::SelBits{1'b1}};
  localparam logic [drd_pkg::SelBits-1:0] SelMid = SelMax >> 1;
  localparam int unsigned RowBits = 2 * drd_pkg::NumWays;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_SCAN, ST_WRITE, ST_DECAY, ST_RESP
  } state_e;

  // set row memories: RRPV row, dead count row, stream count, previous address
  logic [RowBits-1:0]               rrpv_mem [drd_pkg::NumSets];
  logic [RowBits-1:0]               dead_mem [drd_pkg::NumSets];
  logic [1:0]                       strm_mem [drd_pkg::NumSets];
  logic [drd_pkg::AddrBits-1:0]     prev_mem [drd_pkg::NumSets];

  logic [RowBits-1:0]               rrpv_rd, dead_rd;
  logic [1:0]                       strm_rd;
  logic [drd_pkg::AddrBits-1:0]     prev_rd;

  logic                 mem_we;
  logic [SIdx-1:0]      wr_addr, rd_addr;
  logic [RowBits-1:0]   rrpv_wd, dead_wd;
  logic [1:0]           strm_wd;
  logic [drd_pkg::AddrBits-1:0] prev_wd;
  logic                 meta_we; // stream and prev address write

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      rrpv_mem[wr_addr] <= rrpv_wd;
      dead_mem[wr_addr] <= dead_wd;
    end
    if (meta_we) begin
      strm_mem[wr_addr] <= strm_wd;
      prev_mem[wr_addr] <= prev_wd;
    end
    rrpv_rd <= rrpv_mem[rd_addr];
    dead_rd <= dead_mem[rd_addr];
    strm_rd <= strm_mem[rd_addr];
    prev_rd <= prev_mem[rd_addr];
  end

  state_e                      state_q;
  drd_pkg::req_t               req_q;
  logic [SIdx-1:0]             set_q, ptr_q;
  logic [WIdx-1:0]             way_q;
  logic [WIdx-1:0]             vic_q;    // victim way of the current word
  logic [RowBits-1:0]          rrpv_q, dead_q;
  logic [1:0]                  strm_q;
  logic [drd_pkg::SelBits-1:0] sel_q;
  logic [15:0]                 lfsr_q;
  logic [2:0]                  thr_q;
  logic                        aged_q;   // RRPV row aged during the scan
  logic [SIdx-1:0]             dptr_q;   // decay: row being written
  drd_pkg::rsp_t               rsp_q;
  logic                        rsp_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) thr_q <= 3'd3;
    else if (cfg_we_i) thr_q <= cfg_wdata_i;
  end

  // row helpers
  function automatic logic [RowBits-1:0] age_row(input logic [RowBits-1:0] r);
    logic [RowBits-1:0] o;
    for (int w = 0; w < drd_pkg::NumWays; w++)
      o[2*w +: 2] = (r[2*w +: 2] == 2'd3) ? 2'd3 : r[2*w +: 2] + 2'd1;
    return o;
  endfunction

  function automatic logic [RowBits-1:0] decay_row(input logic [RowBits-1:0] r);
    logic [RowBits-1:0] o;
    for (int w = 0; w < drd_pkg::NumWays; w++)
      o[2*w +: 2] = (r[2*w +: 2] == 2'd0) ? 2'd0 : r[2*w +: 2] - 2'd1;
    return o;
  endfunction

  // first way with value 3 in a row
  logic             rr_hit, dd_hit;
  logic [WIdx-1:0]  rr_way, dd_way;
  always_comb begin
    rr_hit = 1'b0; rr_way = '0; dd_hit = 1'b0; dd_way = '0;
    for (int w = drd_pkg::NumWays - 1; w >= 0; w--) begin
      if (rrpv_q[2*w +: 2] == 2'd3) begin rr_hit = 1'b1; rr_way = WIdx'(w); end
      if (dead_q[2*w +: 2] == 2'd3) begin dd_hit = 1'b1; dd_way = WIdx'(w); end
    end
  end

  // streaming detector on the row just read
  logic [drd_pkg::AddrBits-1:0] delta;
  logic                         stride;
  logic [1:0]                   strm_new;
  always_comb begin
    delta  = (req_q.phys_addr > prev_rd) ? req_q.phys_addr - prev_rd
                                         : prev_rd - req_q.phys_addr;
    stride = (prev_rd != '0) &&
             (delta == drd_pkg::StrideOne || delta == drd_pkg::StrideTwo);
    if (stride) strm_new = (strm_rd == 2'd3) ? 2'd3 : strm_rd + 2'd1;
    else        strm_new = (strm_rd == 2'd0) ? 2'd0 : strm_rd - 2'd1;
  end

  logic streaming;
  assign streaming = {1'b0, strm_q} >= thr_q;

  logic lip_lead, bip_lead;
  assign lip_lead = 32'(set_q) < drd_pkg::LeaderSets / 2;
  assign bip_lead = !lip_lead && (32'(set_q) < drd_pkg::LeaderSets);

  logic [15:0] lfsr_nx;
  assign lfsr_nx = {lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5], lfsr_q[15:1]};

  // update results for the addressed way
  logic [1:0] dead_old, dead_new, rrpv_new;
  logic       use_bip;
  always_comb begin
    dead_old = dead_q[2*way_q +: 2];
    use_bip  = lip_lead ? 1'b0 : (bip_lead ? 1'b1 : (sel_q < SelMid));
    if (req_q.was_hit) begin
      dead_new = 2'd0;
      rrpv_new = 2'd0;
    end else begin
      dead_new = (dead_old == 2'd3) ? 2'd3 : dead_old + 2'd1;
      if (streaming) rrpv_new = 2'd3;
      else rrpv_new = (use_bip && lfsr_nx[4:0] == 5'd0) ? 2'd1 : 2'd3;
    end
  end

  logic [RowBits-1:0] rrpv_upd, dead_upd;
  always_comb begin
    rrpv_upd = rrpv_q;
    dead_upd = dead_q;
    rrpv_upd[2*way_q +: 2] = rrpv_new;
    dead_upd[2*way_q +: 2] = dead_new;
  end

  logic req_fire;
  assign req_ready_o = (state_q == ST_IDLE);
  assign req_fire    = req_valid_i && req_ready_o;

  // memory port control
  always_comb begin
    mem_we  = 1'b0;
    meta_we = 1'b0;
    wr_addr = set_q;
    rrpv_wd = rrpv_upd;
    dead_wd = dead_upd;
    strm_wd = strm_q;
    prev_wd = req_q.phys_addr;
    rd_addr = ptr_q;
    // a decay starts its walk at row 0
    if (req_fire)
      rd_addr = (req_i.operation == drd_pkg::OP_DECAY) ? '0
                                                       : req_i.set_index[SIdx-1:0];
    case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1; meta_we = 1'b1; wr_addr = ptr_q;
        rrpv_wd = {RowBits{1'b1}}; dead_wd = '0; strm_wd = 2'd0; prev_wd = '0;
      end
      ST_WRITE: begin
        mem_we  = (req_q.operation == drd_pkg::OP_UPDATE) || aged_q;
        meta_we = (req_q.operation == drd_pkg::OP_UPDATE);
        if (req_q.operation != drd_pkg::OP_UPDATE) begin
          rrpv_wd = rrpv_q; dead_wd = dead_q;
        end
      end
      ST_DECAY: begin
        mem_we = 1'b1; wr_addr = dptr_q;
        rrpv_wd = rrpv_rd; dead_wd = decay_row(dead_rd);
        // last row: read the addressed set for its stream count
        if (32'(dptr_q) == drd_pkg::NumSets - 1) rd_addr = set_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      ptr_q   <= '0;
      dptr_q  <= '0;
      sel_q   <= SelMid;
      lfsr_q  <= drd_pkg::LfsrSeed;
      rsp_v_q <= 1'b0;
      aged_q  <= 1'b0;
    end else begin
      if (rsp_v_q && rsp_ready_i && state_q != ST_RESP) rsp_v_q <= 1'b0;
      case (state_q)
        ST_CLEAR: begin
          if (32'(ptr_q) == drd_pkg::NumSets - 1) begin
            ptr_q <= '0; state_q <= ST_IDLE;
          end else begin
            ptr_q <= ptr_q + SIdx'(1);
          end
        end
        ST_IDLE: if (req_fire) begin
          req_q <= req_i;
          set_q <= req_i.set_index[SIdx-1:0];
          way_q <= req_i.way_index[WIdx-1:0];
          aged_q <= 1'b0;
          case (req_i.operation)
            drd_pkg::OP_VICTIM, drd_pkg::OP_UPDATE: state_q <= ST_READ;
            drd_pkg::OP_DECAY: begin ptr_q <= SIdx'(1);
              dptr_q <= '0; state_q <= ST_DECAY; end
            default: state_q <= ST_READ;
          endcase
        end
        ST_READ: begin
          rrpv_q <= rrpv_rd; dead_q <= dead_rd;
          strm_q <= (req_q.operation == drd_pkg::OP_UPDATE) ? strm_new : strm_rd;
          state_q <= (req_q.operation == drd_pkg::OP_UPDATE) ? ST_WRITE : ST_SCAN;
          vic_q <= '0;
        end
        ST_SCAN: begin
          if (req_q.operation != drd_pkg::OP_VICTIM) begin
            state_q <= ST_WRITE;
          end else if (streaming && !aged_q && !rr_hit) begin
            rrpv_q <= age_row(rrpv_q); aged_q <= 1'b1;
          end else if (streaming && rr_hit) begin
            vic_q <= rr_way; state_q <= ST_WRITE;
          end else if (dd_hit) begin
            vic_q <= dd_way; state_q <= ST_WRITE;
          end else if (rr_hit) begin
            vic_q <= rr_way; state_q <= ST_WRITE;
          end else begin
            rrpv_q <= age_row(rrpv_q); aged_q <= 1'b1;
          end
        end
        ST_WRITE: begin
          if (req_q.operation == drd_pkg::OP_UPDATE && !req_q.was_hit
              && !streaming) begin
            if (use_bip) lfsr_q <= lfsr_nx;
            if (lip_lead && sel_q != SelMax) sel_q <= sel_q + 1'b1;
            else if (bip_lead && sel_q != '0) sel_q <= sel_q - 1'b1;
          end
          state_q <= ST_RESP;
        end
        ST_DECAY: begin
          // read row ptr_q while writing back row dptr_q
          ptr_q  <= ptr_q + SIdx'(1);
          dptr_q <= dptr_q + SIdx'(1);
          if (32'(dptr_q) == drd_pkg::NumSets - 1) state_q <= ST_READ;
        end
        ST_RESP: begin
          // strm_q holds the set's stream count after the step
          if (!rsp_v_q || rsp_ready_i) begin
            rsp_q.victim_way    <= vic_q;
            rsp_q.set_streaming <= ({1'b0, strm_q} >= thr_q);
            rsp_q.duel_counter  <= sel_q;
            rsp_v_q <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign rsp_valid_o = rsp_v_q;
  assign rsp_o       = rsp_q;

  a_one_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESP && (!rsp_v_q || rsp_ready_i)) |=> rsp_v_q)
    else $error("response not raised");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !req_ready_o)
    else $error("accept while busy");
  a_sel_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_WRITE) |=> $stable(sel_q))
    else $error("selector moved outside write");

endmodule

@@ test/dip_rrip_deadblock_stream_replacement_test.sv @@
module dip_rrip_deadblock_stream_replacement_test;

  localparam int unsigned Sets    = 2048;
  localparam int unsigned Ways    = 16;
  localparam int unsigned Leaders = 64;
  localparam logic [9:0]  SelMax  = 10'd1023;
  localparam logic [9:0]  SelMid  = 10'd511;
  // Quiet cycles allowed: reset clearing pass, a decay walk, plus long stalls.
  localparam int unsigned StallLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_wdata_i = 3'd3;
  logic req_valid_i = 1'b0;
  logic req_ready_o;
  drd_pkg::req_t req_i = '0;
  logic rsp_valid_o;
  logic rsp_ready_i = 1'b0;
  drd_pkg::rsp_t rsp_o;

  always #1 clk_i = ~clk_i;

  dip_rrip_deadblock_stream_replacement dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .req_valid_i(req_valid_i), .req_ready_o(req_ready_o), .req_i(req_i),
    .rsp_valid_o(rsp_valid_o), .rsp_ready_i(rsp_ready_i), .rsp_o(rsp_o)
  );

  // Shadow of the policy state.
  logic [1:0]  rrpv_mem [Sets*Ways];
  logic [1:0]  dead_mem [Sets*Ways];
  logic [1:0]  stream_mem [Sets];
  logic [63:0] last_addr_mem [Sets];
  logic [9:0]  psel;
  logic [15:0] lfsr;
  logic [2:0]  threshold;

  drd_pkg::rsp_t pending_rsp[$];
  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;
  logic [63:0] hot_addr [Sets];  // per-set stride stream generator

  function automatic logic streaming(int unsigned s);
    return {1'b0, stream_mem[s]} >= threshold;
  endfunction

  function automatic int find_rrpv3(int unsigned base);
    for (int w = 0; w < Ways; w++)
      if (rrpv_mem[base+w] == 2'd3) return w;
    return -1;
  endfunction

  function automatic void age_row(int unsigned base);
    for (int w = 0; w < Ways; w++)
      if (rrpv_mem[base+w] != 2'd3) rrpv_mem[base+w]++;
  endfunction

  function automatic logic [3:0] choose_victim(int unsigned s);
    int unsigned base;
    int found;
    base = s * Ways;
    if (streaming(s)) begin
      found = find_rrpv3(base);
      if (found >= 0) return found[3:0];
      age_row(base);
      found = find_rrpv3(base);
      if (found >= 0) return found[3:0];
    end
    for (int w = 0; w < Ways; w++)
      if (dead_mem[base+w] == 2'd3) return w[3:0];
    forever begin
      found = find_rrpv3(base);
      if (found >= 0) return found[3:0];
      age_row(base);
    end
  endfunction

  function automatic logic bip_draw();
    logic fb;
    fb = lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5];
    lfsr = {fb, lfsr[15:1]};
    return lfsr[4:0] == 5'd0;
  endfunction

  function automatic void apply_update(int unsigned s, int unsigned w,
                                       logic [63:0] addr, logic hit);
    int unsigned i;
    logic [63:0] last, delta;
    logic lip, bip, use_bip;
    i = s * Ways + w;
    last = last_addr_mem[s];
    delta = (addr > last) ? addr - last : last - addr;
    if (last != 0 && (delta == drd_pkg::StrideOne || delta == drd_pkg::StrideTwo)) begin
      if (stream_mem[s] != 2'd3) stream_mem[s]++;
    end else if (stream_mem[s] != 2'd0) begin
      stream_mem[s]--;
    end
    last_addr_mem[s] = addr;
    if (hit) begin
      dead_mem[i] = 2'd0;
      rrpv_mem[i] = 2'd0;
      return;
    end
    if (dead_mem[i] != 2'd3) dead_mem[i]++;
    if (streaming(s)) begin
      rrpv_mem[i] = 2'd3;
      return;
    end
    lip = s < Leaders / 2;
    bip = !lip && s < Leaders;
    use_bip = lip ? 1'b0 : bip ? 1'b1 : (psel < SelMid);
    rrpv_mem[i] = (use_bip && bip_draw()) ? 2'd1 : 2'd3;
    if (lip && psel != SelMax) psel++;
    else if (bip && psel != 10'd0) psel--;
  endfunction

  function automatic drd_pkg::rsp_t predict_word(drd_pkg::req_t r);
    drd_pkg::rsp_t o;
    int unsigned s;
    s = r.set_index;
    o = '0;
    case (drd_pkg::op_e'(r.operation))
      drd_pkg::OP_VICTIM: o.victim_way = choose_victim(s);
      drd_pkg::OP_UPDATE: apply_update(s, r.way_index, r.phys_addr, r.was_hit);
      drd_pkg::OP_DECAY: begin
        for (int i = 0; i < Sets*Ways; i++)
          if (dead_mem[i] != 2'd0) dead_mem[i]--;
      end
      default: ;
    endcase
    o.set_streaming = streaming(s);
    o.duel_counter = psel;
    return o;
  endfunction

  // Sender: bursts and gaps; valid stays up across back-to-back words.
  int unsigned burst_left = 0;

  task automatic send_word(drd_pkg::req_t r);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
      if (gap != 0) begin
        req_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    req_valid_i <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (!req_ready_o);
    pending_rsp.push_back(predict_word(r));
    burst_left--;
  endtask

  task automatic drain();
    @(posedge clk_i);
    req_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (Sets + 16) @(posedge clk_i);
  endtask

  task automatic set_threshold(logic [2:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    threshold = v;
  endtask

  function automatic drd_pkg::req_t make_word(drd_pkg::op_e op, int unsigned s,
                                              int unsigned w, logic [63:0] a,
                                              logic h);
    drd_pkg::req_t r;
    r.operation = op;
    r.set_index = s[10:0];
    r.way_index = w[3:0];
    r.phys_addr = a;
    r.was_hit = h;
    return r;
  endfunction

  // Receiver stalls on a rotating pattern, with stall-free stretches.
  int unsigned rx_phase = 0;
  always @(posedge clk_i) begin
    rx_phase <= rx_phase + 1;
    rsp_ready_i <= (rx_phase[9:8] == 2'd0) ? 1'b1 : ($urandom_range(0, 3) != 0);
  end

  // Response checker and watchdog.
  always @(posedge clk_i) begin
    drd_pkg::rsp_t want;
    if ((req_valid_i && req_ready_o) || (rsp_valid_o && rsp_ready_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > StallLimit) begin
      $display("dip_rrip_deadblock_stream_replacement regression: fail");
      $finish;
    end
    if (rst_ni && rsp_valid_o && rsp_ready_i) begin
      if (pending_rsp.size() == 0) begin
        $error("unexpected response word %h", rsp_o);
        fail_count++;
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_o.victim_way !== want.victim_way) begin
          $error("victim_way exp %0d got %0d", want.victim_way, rsp_o.victim_way);
          fail_count++;
        end
        if (rsp_o.set_streaming !== want.set_streaming) begin
          $error("set_streaming exp %0d got %0d", want.set_streaming,
                 rsp_o.set_streaming);
          fail_count++;
        end
        if (rsp_o.duel_counter !== want.duel_counter) begin
          $error("duel_counter exp %0d got %0d", want.duel_counter,
                 rsp_o.duel_counter);
          fail_count++;
        end
      end
    end
  end

  // Directed: field extremes, every opcode, stride hits, threshold 0.
  task automatic test_directed();
    send_word(make_word(drd_pkg::OP_VICTIM, 0, 0, '0, 1'b0));
    send_word(make_word(drd_pkg::OP_VICTIM, Sets-1, 15, '1, 1'b1));
    send_word(make_word(drd_pkg::OP_UPDATE, 5, 3, 64'h1000, 1'b0));
    send_word(make_word(drd_pkg::OP_UPDATE, 5, 3, 64'h1040, 1'b0));   // +64 stride
    send_word(make_word(drd_pkg::OP_UPDATE, 5, 4, 64'h10C0, 1'b0));   // +128 stride
    send_word(make_word(drd_pkg::OP_UPDATE, 5, 5, 64'h1080, 1'b1));   // -64, hit
    send_word(make_word(drd_pkg::OP_VICTIM, 5, 0, '0, 1'b0));
    send_word(make_word(drd_pkg::OP_UPDATE, 40, 15, '1, 1'b0));       // BIP leader miss
    send_word(make_word(drd_pkg::OP_UPDATE, Sets-1, 15, '1, 1'b0));   // follower miss
    send_word(make_word(drd_pkg::OP_UPDATE, 1, 2, 64'h5000, 1'b0));   // same way thrice
    send_word(make_word(drd_pkg::OP_UPDATE, 1, 2, 64'h9000, 1'b0));
    send_word(make_word(drd_pkg::OP_UPDATE, 1, 2, 64'hF000, 1'b0));
    send_word(make_word(drd_pkg::OP_VICTIM, 1, 0, '0, 1'b0));         // dead way wins
    send_word(make_word(drd_pkg::OP_DECAY, 1, 0, '0, 1'b0));
    send_word(make_word(drd_pkg::OP_NONE, 7, 9, 64'h55, 1'b1));
    send_word(make_word(drd_pkg::OP_UPDATE, 1, 0, 64'h100, 1'b1));    // hit clears way 0's RRPV and dead count
    for (int w = 1; w < 4; w++)
      send_word(make_word(drd_pkg::OP_VICTIM, 1, 0, '0, 1'b0));
    set_threshold(3'd0);                                              // all sets stream
    send_word(make_word(drd_pkg::OP_VICTIM, 9, 0, '0, 1'b0));
    send_word(make_word(drd_pkg::OP_UPDATE, 9, 1, 64'h40, 1'b0));
  endtask

  // Random: mostly strided streams into a pool of sets up to pool_max, with noise.
  task automatic test_random(int unsigned count, int unsigned pool_max);
    int unsigned s, pick;
    logic [63:0] a;
    for (int n = 0; n < count; n++) begin
      s = ($urandom_range(0, 3) == 0) ? $urandom_range(0, Sets-1)
                                      : $urandom_range(0, pool_max);
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        send_word(make_word(drd_pkg::OP_VICTIM, s, $urandom_range(0, 15),
                            {$urandom, $urandom}, $urandom_range(0, 1) != 0));
      end else if (pick < 97) begin
        if ($urandom_range(0, 2) != 0 && hot_addr[s] != 0)
          a = hot_addr[s] + (($urandom_range(0, 1) != 0) ? 64'd64 : 64'd128);
        else
          a = {$urandom, $urandom};
        if ($urandom_range(0, 9) == 0) a = 64'($urandom_range(0, 200));
        hot_addr[s] = a;
        send_word(make_word(drd_pkg::OP_UPDATE, s, $urandom_range(0, 15), a,
                            $urandom_range(0, 2) == 0));
      end else if (pick < 99) begin
        send_word(make_word(drd_pkg::OP_NONE, s, $urandom_range(0, 15),
                            {$urandom, $urandom}, $urandom_range(0, 1) != 0));
      end else begin
        send_word(make_word(drd_pkg::OP_DECAY, s, 0, '0, 1'b0));
      end
    end
  endtask

  // Threshold sweep including the maximum and settings that disable streaming.
  task automatic test_thresholds();
    logic [2:0] sweep [5] = '{3'd1, 3'd4, 3'd2, 3'd7, 3'd3};
    foreach (sweep[k]) begin
      set_threshold(sweep[k]);
      test_random(240, (k % 2) ? 70 : 2047);
    end
  endtask

  initial begin
    for (int i = 0; i < Sets*Ways; i++) begin
      rrpv_mem[i] = 2'd3;
      dead_mem[i] = 2'd0;
    end
    for (int i = 0; i < Sets; i++) begin
      stream_mem[i] = 2'd0;
      last_addr_mem[i] = '0;
      hot_addr[i] = '0;
    end
    psel = SelMid;
    lfsr = drd_pkg::LfsrSeed;
    threshold = 3'd3;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_thresholds();
    drain();
    if (fail_count == 0)
      $display("dip_rrip_deadblock_stream_replacement regression: pass");
    else
      $display("dip_rrip_deadblock_stream_replacement regression: fail");
    $finish;
  end

endmodule

@@ files.f @@
sv/drd_pkg.sv
sv/dip_rrip_deadblock_stream_replacement.sv
test/dip_rrip_deadblock_stream_replacement_test.sv
